### rtl/asl_pkg.sv
// ----------------------------------------------------------------------------
// Accumulating slot line package
// Sizes, derived widths, item codes and the structures passed between the
// slot cells, the waiting FIFO and the top level.
// ----------------------------------------------------------------------------
package asl_pkg;

    localparam int LINE_SLOTS = 1024;
    localparam int WAIT_DEPTH = 64;
    localparam int ID_BITS    = 16;

    localparam int LAST_SLOT  = LINE_SLOTS - 1;
    localparam int WAIT_IDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int WAIT_CNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int LINE_CNT_W = $clog2(LINE_SLOTS + 1);

    // Widths of the fields on the ports, fixed by the word formats.
    localparam int USER_W       = 16;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_FIELDS_W = 1 + USER_W + 1 + USER_W + 1 + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic {
        ACT_TICK   = 1'b0,
        ACT_INSERT = 1'b1
    } action_t;

    // What one slot holds, and what it offers to the slot above it.
    typedef struct packed {
        logic               occ;
        logic [ID_BITS-1:0] user;
    } slot_state_t;

    // Status of the waiting FIFO as seen by the line.
    typedef struct packed {
        logic               full;
        logic               not_empty;
        logic [ID_BITS-1:0] head;
    } wait_status_t;

endpackage

### rtl/asl_slot_cell.sv
// ----------------------------------------------------------------------------
// Slot cell
// One place of the line. On a tick it keeps its user, or the last place lets
// it leave, if it and all places above are occupied; else takes the one below.
// ----------------------------------------------------------------------------
module asl_slot_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                leave_when_held,
    input  logic                blocked_in,
    input  asl_pkg::slot_state_t below,
    output asl_pkg::slot_state_t held,
    output logic                blocked_out
);
    import asl_pkg::*;

    logic               occ_reg;
    logic               occ_next;
    logic [ID_BITS-1:0] user_reg;
    logic [ID_BITS-1:0] user_next;

    // A cell is blocked when it and every cell above it are occupied.
    assign blocked_out = occ_reg & blocked_in;

    assign held.occ  = occ_reg;
    assign held.user = user_reg;

    always_comb
    begin
        occ_next  = occ_reg;
        user_next = user_reg;
        if (advance)
        begin
            if (blocked_out)
            begin
                occ_next = ~leave_when_held;
            end
            else
            begin
                occ_next  = below.occ;
                user_next = below.user;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        user_reg <= user_next;
    end

endmodule

### rtl/asl_wait_fifo.sv
// ----------------------------------------------------------------------------
// Waiting FIFO
// Circular store of user ids waiting for the first slot. The head word is
// kept registered so that the line can take it in the cycle of a tick.
// ----------------------------------------------------------------------------
module asl_wait_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        pop,
    input  logic [asl_pkg::ID_BITS-1:0] push_id,
    output asl_pkg::wait_status_t       status
);
    import asl_pkg::*;

    logic [ID_BITS-1:0]    mem [WAIT_DEPTH];
    logic [ID_BITS-1:0]    head_data_reg;
    logic [WAIT_IDX_W-1:0] head_reg;
    logic [WAIT_IDX_W-1:0] head_next;
    logic [WAIT_IDX_W-1:0] tail_reg;
    logic [WAIT_IDX_W-1:0] tail_next;
    logic [WAIT_CNT_W-1:0] count_reg;
    logic [WAIT_CNT_W-1:0] count_next;

    always_comb
    begin
        head_next = head_reg;
        if (pop)
        begin
            head_next = (head_reg == WAIT_IDX_W'(WAIT_DEPTH - 1)) ? '0
                                                                  : head_reg + WAIT_IDX_W'(1);
        end
        tail_next = tail_reg;
        if (push)
        begin
            tail_next = (tail_reg == WAIT_IDX_W'(WAIT_DEPTH - 1)) ? '0
                                                                  : tail_reg + WAIT_IDX_W'(1);
        end
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + WAIT_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - WAIT_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // The read port follows the next head; a word written into an empty
    // FIFO lands at that same place and is forwarded straight to the head.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_id;
        end
        if (push && (tail_reg == head_next))
        begin
            head_data_reg <= push_id;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

    assign status.full      = (count_reg == WAIT_CNT_W'(WAIT_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign status.head      = head_data_reg;

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= WAIT_CNT_W'(WAIT_DEPTH))
        else $error("waiting FIFO count beyond its depth");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into a full waiting FIFO");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (status.not_empty && !push))
        else $error("pop from an empty waiting FIFO or pop with push");
`endif

endmodule

### rtl/accumulating_slot_line_unit.sv
// ----------------------------------------------------------------------------
// Accumulating slot line unit
// A line of slots fed by a waiting FIFO of user ids.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: s_axis_tuser[0] selects the item (0 = tick,
// 1 = insert) and s_axis_tdata carries the user id for an insert. Every input
// word yields exactly one result word on m_axis.
// An insert pushes the id into the waiting FIFO or, if it is full, flags it
// as dropped. A tick moves every unblocked slot up one place, fills a vacant
// first slot from the FIFO head and reports starts, arrivals at the last
// slot and whether the line is empty.
// Each word is processed in the cycle of its acceptance; the blocked state
// ripples down the row of slot cells from the last slot within that cycle.
// The result is registered, and one word per cycle is sustained while the
// receiver keeps m_axis_tready high.
// While a result is held in the output register and m_axis_tready is low,
// s_axis_tready stays low and no further word is taken.
// Reset empties the line and the waiting FIFO; no clearing pass is needed.
// ----------------------------------------------------------------------------
module accumulating_slot_line_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] user_id
    input  logic [asl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] action
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] started_valid, [16:1] started_user, [17] ended_valid,
    // [33:18] ended_user, [34] line_empty, [35] insert_dropped, [39:36] zero
    output logic [asl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import asl_pkg::*;

    slot_state_t           held [LINE_SLOTS];
    logic [LINE_SLOTS-1:0] blocked;
    slot_state_t           feed;
    wait_status_t          wait_status;

    logic                  in_fire;
    logic                  advance;
    logic                  is_insert;
    logic                  push;
    logic                  pop;
    logic                  started;
    logic                  ended;
    logic                  leaving;
    logic                  dropped;
    logic [ID_BITS-1:0]    in_id;

    logic [LINE_CNT_W-1:0] line_cnt_reg;
    logic [LINE_CNT_W-1:0] line_cnt_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic [USER_W-1:0]     started_user;
    logic [USER_W-1:0]     ended_user;

    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign is_insert     = (action_t'(s_axis_tuser[0]) == ACT_INSERT);
    assign advance       = in_fire & ~is_insert;
    assign in_id         = ID_BITS'(s_axis_tdata);

    // The first cell sees the FIFO head as the slot below it.
    assign feed.occ  = wait_status.not_empty;
    assign feed.user = wait_status.head;

    assign started = ~blocked[0] & wait_status.not_empty;
    assign leaving = held[LAST_SLOT].occ;
    assign ended   = ~held[LAST_SLOT].occ & held[LAST_SLOT-1].occ;
    assign pop     = advance & started;
    assign push    = in_fire & is_insert & ~wait_status.full;
    assign dropped = is_insert & wait_status.full;

    generate
        for (genvar i = 0; i < LINE_SLOTS; i++)
        begin : g_slot
            slot_state_t below_i;
            logic        blocked_in_i;

            if (i == 0)
            begin : g_first
                assign below_i = feed;
            end
            else
            begin : g_inner
                assign below_i = held[i-1];
            end

            if (i == LAST_SLOT)
            begin : g_last
                assign blocked_in_i = 1'b1;
            end
            else
            begin : g_mid
                assign blocked_in_i = blocked[i+1];
            end

            asl_slot_cell u_cell (
                .clk             (clk),
                .rst_n           (rst_n),
                .advance         (advance),
                .leave_when_held ((i == LAST_SLOT) ? 1'b1 : 1'b0),
                .blocked_in      (blocked_in_i),
                .below           (below_i),
                .held            (held[i]),
                .blocked_out     (blocked[i])
            );
        end
    endgenerate

    asl_wait_fifo u_wait_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .push_id (in_id),
        .status  (wait_status)
    );

    // Number of users in the line, so that emptiness needs no wide OR.
    always_comb
    begin
        line_cnt_next = line_cnt_reg;
        if (advance)
        begin
            if (started && !leaving)
            begin
                line_cnt_next = line_cnt_reg + LINE_CNT_W'(1);
            end
            else if (!started && leaving)
            begin
                line_cnt_next = line_cnt_reg - LINE_CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        started_user = '0;
        ended_user   = '0;
        if (!is_insert && started)
        begin
            started_user = USER_W'(wait_status.head);
        end
        if (!is_insert && ended)
        begin
            ended_user = USER_W'(held[LAST_SLOT-1].user);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_TDATA_W'({
                dropped,
                (line_cnt_next == '0),
                ended_user,
                ~is_insert & ended,
                started_user,
                ~is_insert & started
            });
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            line_cnt_reg  <= line_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    a_line_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        line_cnt_reg <= LINE_CNT_W'(LINE_SLOTS))
        else $error("line count beyond the number of slots");

    a_empty_line_has_no_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (line_cnt_reg == '0) |-> (!held[0].occ && !held[LAST_SLOT].occ))
        else $error("line count zero while an end slot is occupied");

    a_last_slot_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && held[LAST_SLOT].occ) |=> !held[LAST_SLOT].occ)
        else $error("user stayed in the last slot over a tick");
`endif

endmodule

### dv/accumulating_slot_line_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accumulating slot line unit testbench
// Drives tick and insert words into the unit with random idle cycles on both
// sides and a long receiver hold-off. Every input word is run through a
// behavioural copy of the slot line and its waiting FIFO. Each result word is
// compared field by field with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module accumulating_slot_line_unit_test;

    import asl_pkg::*;

    // Result word layout, highest field first.
    typedef struct packed {
        logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
        logic                                insert_dropped;
        logic                                line_empty;
        logic [USER_W-1:0]                   ended_user;
        logic                                ended_valid;
        logic [USER_W-1:0]                   started_user;
        logic                                started_valid;
    } line_result_t;

    class slot_line_scoreboard;
        bit                occupied[LINE_SLOTS];
        bit [USER_W-1:0]   occupant[LINE_SLOTS];
        bit [USER_W-1:0]   waiting[$];
        line_result_t      due_results[$];
        int                errors;
        int                ended_total;

        // Works out the result of one accepted word and, for a tick, advances the line.
        function void predict_line_step(action_t act, logic [IN_TDATA_W-1:0] id);
            line_result_t r;
            bit           end_free;
            bit           any_held;
            r = '0;
            if (act == ACT_INSERT) begin
                if (waiting.size() >= WAIT_DEPTH)
                    r.insert_dropped = 1'b1;
                else
                    waiting.insert(waiting.size(), id[USER_W-1:0]);
            end
            else begin
                end_free = !occupied[LAST_SLOT];
                // Walking down from the top, a user only moves into a slot
                // that the slots above have already vacated.
                for (int i = LAST_SLOT; i > 0; i--) begin
                    if (!occupied[i] && occupied[i-1]) begin
                        occupied[i]   = 1'b1;
                        occupant[i]   = occupant[i-1];
                        occupied[i-1] = 1'b0;
                    end
                end
                if (!occupied[0] && waiting.size() > 0) begin
                    occupied[0]    = 1'b1;
                    occupant[0]    = waiting[0];
                    waiting.delete(0);
                    r.started_valid = 1'b1;
                    r.started_user  = occupant[0];
                end
                if (end_free) begin
                    if (occupied[LAST_SLOT]) begin
                        r.ended_valid = 1'b1;
                        r.ended_user  = occupant[LAST_SLOT];
                        ended_total++;
                    end
                end
                else begin
                    occupied[LAST_SLOT] = 1'b0;
                end
            end
            any_held = 1'b0;
            foreach (occupied[i])
                if (occupied[i])
                    any_held = 1'b1;
            r.line_empty = !any_held;
            due_results.insert(due_results.size(), r);
        endfunction

        function void check_field(string name, logic [USER_W-1:0] expv,
                                  logic [USER_W-1:0] gotv);
            if (gotv !== expv) begin
                $error("%s: expected %h, got %h", name, expv, gotv);
                errors++;
            end
        endfunction

        function void check_line_result(line_result_t got);
            line_result_t want;
            if (due_results.size() == 0) begin
                $error("result word %h arrived with no prediction outstanding", got);
                errors++;
                return;
            end
            want = due_results[0];
            due_results.delete(0);
            check_field("started_valid",  want.started_valid,  got.started_valid);
            check_field("started_user",   want.started_user,   got.started_user);
            check_field("ended_valid",    want.ended_valid,    got.ended_valid);
            check_field("ended_user",     want.ended_user,     got.ended_user);
            check_field("line_empty",     want.line_empty,     got.line_empty);
            check_field("insert_dropped", want.insert_dropped, got.insert_dropped);
            check_field("pad",            want.pad,            got.pad);
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_TDATA_W-1:0]       s_axis_tdata  = '0;
    logic [0:0]                  s_axis_tuser  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]      m_axis_tdata;

    slot_line_scoreboard sb;
    bit                  tx_idle = 1'b1;
    bit                  rx_idle = 1'b1;

    accumulating_slot_line_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Entered just after a rising edge; returns just after the accepting edge.
    task automatic send_word(action_t act, logic [IN_TDATA_W-1:0] id);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= id;
        s_axis_tuser  <= act;
        // Handshake inputs settle by the falling edge and hold until the next
        // rising edge, so sampling there is free of races.
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        sb.predict_line_step(act, id);
    endtask

    task automatic take_result();
        int           stall;
        line_result_t got;
        stall = rx_idle ? $urandom_range(0, 4) : 0;
        if (stall > 0)
        begin
            m_axis_tready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
        do @(negedge clk); while (!m_axis_tvalid);
        got = m_axis_tdata;
        @(posedge clk);
        sb.check_line_result(got);
    endtask

    task automatic send_burst(action_t act, int count);
        repeat (count) send_word(act, IN_TDATA_W'($urandom_range(0, 16'hFFFF)));
    endtask

    initial
    begin
        int words_taken;
        words_taken = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            // A long hold-off lets the output word back up into the input.
            if (words_taken == 400)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            take_result();
            words_taken++;
            if ($urandom_range(0, 39) == 0)
                rx_idle = !rx_idle;
        end
    end

    initial
    begin
        int random_words;
        int pick;
        int len;
        sb = new;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tick on an empty line with an empty FIFO.
        send_word(ACT_TICK, 16'hFFFF);
        send_word(ACT_INSERT, 16'h0000);
        send_word(ACT_INSERT, 16'hFFFF);
        send_word(ACT_TICK, 16'h1234);
        send_word(ACT_TICK, 16'h0000);
        // The FIFO is empty now, so the first slot stays vacant.
        send_word(ACT_TICK, 16'hFFFF);
        send_word(ACT_INSERT, 16'hAAAA);
        send_word(ACT_INSERT, 16'h5555);
        send_word(ACT_INSERT, 16'h0001);
        send_word(ACT_INSERT, 16'h8000);
        send_word(ACT_TICK, 16'h5555);
        send_word(ACT_TICK, 16'hAAAA);
        send_word(ACT_TICK, 16'h0000);
        send_word(ACT_TICK, 16'h0000);
        send_word(ACT_TICK, 16'h0000);

        // Overrun the waiting FIFO early so that drops are flagged, then
        // mix short insert bursts, long dense ones and runs of ticks until
        // users have been reaching the last slot for a while.
        send_burst(ACT_INSERT, 70);
        random_words = 70;
        while ((random_words < 1000 || sb.ended_total < 48) && random_words < 8000)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 5)
                len = $urandom_range(1, 6);
            else if (pick == 5)
                len = $urandom_range(60, 80);
            else
                len = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0)
                tx_idle = !tx_idle;
            send_burst(pick <= 5 ? ACT_INSERT : ACT_TICK, len);
            random_words += len;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
